// ----- src/gpc_pkg.sv -----
`timescale 1ns / 1ps
// Gamepad report conditioner: shared types and constants.
// No dependencies; used by every module of the block.
package gpc_pkg;

    localparam logic [14:0] FULL_SCALE = 15'd32767;
    localparam logic [14:0] ZONE_RESET = 15'd7849;

    localparam logic REG_LEFT_ZONE  = 1'b0;
    localparam logic REG_RIGHT_ZONE = 1'b1;

    typedef struct packed {
        logic [15:0]        button_mask;
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
    } gpc_in_t;

    typedef struct packed {
        logic [15:0]        held_mask;
        logic [15:0]        pressed_mask;
        logic [15:0]        released_mask;
        logic signed [15:0] left_dir_x;
        logic signed [15:0] left_dir_y;
        logic signed [15:0] right_dir_x;
        logic signed [15:0] right_dir_y;
    } gpc_out_t;

    // queue entry between front and back
    typedef struct packed {
        logic [15:0]        held_mask;
        logic [15:0]        pressed_mask;
        logic [15:0]        released_mask;
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
    } gpc_item_t;

endpackage

// ----- src/gamepad_report_conditioner.sv -----
`timescale 1ns / 1ps
// Gamepad report conditioner: button edge masks and radial dead zone per stick.
// The back end works on one word at a time and finishes both sticks before it takes the next,
// running the shared 16-step square root and 16-step dividers once per stick.
// A 2-word queue takes new words while the back end works; results wait in m_data.
// Reset (aresetn low, synchronous) clears queue, previous buttons and sets zones to 7849.
module gamepad_report_conditioner import gpc_pkg::*; #(
    parameter int BUTTON_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  gpc_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output gpc_out_t    m_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [14:0] cfg_wdata
);

    logic [14:0] left_zone_reg, right_zone_reg;
    logic        q_valid, q_ready;
    gpc_item_t   q_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_zone_reg  <= ZONE_RESET;
            right_zone_reg <= ZONE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_LEFT_ZONE:  left_zone_reg  <= cfg_wdata;
                REG_RIGHT_ZONE: right_zone_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    gpc_front #(.BUTTON_BITS(BUTTON_BITS)) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data)
    );

    gpc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_data     (q_data),
        .left_zone  (left_zone_reg),
        .right_zone (right_zone_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    a_pressed_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.pressed_mask & ~m_data.held_mask) == 16'd0))
        else $error("pressed button not held");

    a_released_up: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.released_mask & m_data.held_mask) == 16'd0))
        else $error("released button still held");

    a_dir_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.left_dir_x != 16'sh8000 && m_data.left_dir_y != 16'sh8000
                     && m_data.right_dir_x != 16'sh8000 && m_data.right_dir_y != 16'sh8000))
        else $error("direction outside saturation range");

endmodule

// ----- src/gpc_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts input words, classifies buttons, queues words for the back end.
// Depends on gpc_pkg.
module gpc_front import gpc_pkg::*; #(
    parameter int BUTTON_BITS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  gpc_in_t   s_data,
    output logic      q_valid,
    input  logic      q_ready,
    output gpc_item_t q_data
);

    localparam int BW = (BUTTON_BITS > 16) ? 16 : BUTTON_BITS;

    logic [BW-1:0] prev_reg;
    gpc_item_t     mem_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    count_reg;
    gpc_item_t     entry;
    logic          push, pop;

    always_comb begin
        entry = '0;
        entry.held_mask[BW-1:0]     = s_data.button_mask[BW-1:0];
        entry.pressed_mask[BW-1:0]  = ~prev_reg & s_data.button_mask[BW-1:0];
        entry.released_mask[BW-1:0] = prev_reg & ~s_data.button_mask[BW-1:0];
        entry.left_x  = s_data.left_x;
        entry.left_y  = s_data.left_y;
        entry.right_x = s_data.right_x;
        entry.right_y = s_data.right_y;
    end

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_data  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg   <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                prev_reg   <= s_data.button_mask[BW-1:0];
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

// ----- src/gpc_back.sv -----
`timescale 1ns / 1ps
// Back end: shared square root and two dividers scale each stick, then the output register.
// Depends on gpc_pkg.
module gpc_back import gpc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  gpc_item_t   q_data,
    input  logic [14:0] left_zone,
    input  logic [14:0] right_zone,
    output logic        m_valid,
    input  logic        m_ready,
    output gpc_out_t    m_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_SQRT = 3'd3;
    localparam logic [2:0] ST_CHK  = 3'd4;
    localparam logic [2:0] ST_MUL  = 3'd5;
    localparam logic [2:0] ST_DVLD = 3'd6;
    localparam logic [2:0] ST_DIV  = 3'd7;

    logic [2:0]  state_reg;
    logic        stick_reg;
    logic [3:0]  cnt_reg;
    gpc_item_t   item_reg;
    logic [31:0] sqx_reg, sqy_reg, rad_reg;
    logic [18:0] srem_reg;
    logic [15:0] root_reg;
    logic        zero_reg;
    logic [14:0] diff_reg, span_reg;
    logic [15:0] uax_reg, uay_reg, mag_reg;
    logic        negx_reg, negy_reg;
    logic [30:0] den_reg;
    logic [31:0] rx_reg, ry_reg;
    logic [15:0] lox_reg, loy_reg, qx_reg, qy_reg;
    logic signed [15:0] dx_reg, dy_reg;
    logic signed [15:0] left_dx_reg, left_dy_reg;
    logic        m_valid_reg;
    gpc_out_t    m_data_reg;

    logic signed [15:0] ax, ay;
    logic [14:0] zone, mclip;
    logic [18:0] s_try, s_trial;
    logic [30:0] prod_x, prod_y;
    logic [31:0] tx, ty;
    logic [15:0] qx_next, qy_next;
    logic signed [15:0] dx_next, dy_next;

    function automatic logic signed [15:0] finish(input logic [15:0] q, input logic neg);
        logic [15:0] sat;
        sat = (q > 16'd32767) ? 16'd32767 : q;
        return neg ? -sat : sat;
    endfunction

    always_comb begin
        ax      = stick_reg ? item_reg.right_x : item_reg.left_x;
        ay      = stick_reg ? item_reg.right_y : item_reg.left_y;
        zone    = stick_reg ? right_zone : left_zone;
        mclip   = (mag_reg > 16'd32767) ? FULL_SCALE : mag_reg[14:0];
        s_try   = {srem_reg[16:0], rad_reg[31:30]};
        s_trial = {1'b0, root_reg, 2'b01};
        prod_x  = 31'(uax_reg) * 31'(diff_reg);
        prod_y  = 31'(uay_reg) * 31'(diff_reg);
        tx      = {rx_reg[30:0], lox_reg[15]};
        ty      = {ry_reg[30:0], loy_reg[15]};
        qx_next = {qx_reg[14:0], (tx >= {1'b0, den_reg})};
        qy_next = {qy_reg[14:0], (ty >= {1'b0, den_reg})};
        dx_next = zero_reg ? 16'sd0 : finish(qx_next, negx_reg);
        dy_next = zero_reg ? 16'sd0 : finish(qy_next, negy_reg);
    end

    assign q_ready = (state_reg == ST_IDLE) && !stick_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            stick_reg   <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_IDLE && stick_reg && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (stick_reg) begin
                        // hold the finished word until the output register frees
                        if (!m_valid_reg || m_ready) begin
                            stick_reg <= 1'b0;
                        end
                    end else if (q_valid) begin
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ:   state_reg <= ST_SUM;
                ST_SUM: begin
                    cnt_reg   <= '0;
                    state_reg <= ST_SQRT;
                end
                ST_SQRT: begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15) begin
                        state_reg <= ST_CHK;
                    end
                end
                ST_CHK:  state_reg <= ST_MUL;
                ST_MUL:  state_reg <= ST_DVLD;
                ST_DVLD: begin
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15) begin
                        if (stick_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            stick_reg <= 1'b1;
                            state_reg <= ST_SQ;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (stick_reg) begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.held_mask     <= item_reg.held_mask;
                        m_data_reg.pressed_mask  <= item_reg.pressed_mask;
                        m_data_reg.released_mask <= item_reg.released_mask;
                        m_data_reg.left_dir_x    <= left_dx_reg;
                        m_data_reg.left_dir_y    <= left_dy_reg;
                        m_data_reg.right_dir_x   <= dx_reg;
                        m_data_reg.right_dir_y   <= dy_reg;
                    end
                end else if (q_valid) begin
                    item_reg <= q_data;
                end
            end
            ST_SQ: begin
                sqx_reg <= $unsigned(32'(ax) * 32'(ax));
                sqy_reg <= $unsigned(32'(ay) * 32'(ay));
            end
            ST_SUM: begin
                rad_reg  <= sqx_reg + sqy_reg;
                srem_reg <= '0;
                root_reg <= '0;
            end
            ST_SQRT: begin
                rad_reg <= {rad_reg[29:0], 2'b00};
                if (s_try >= s_trial) begin
                    srem_reg <= s_try - s_trial;
                    root_reg <= {root_reg[14:0], 1'b1};
                end else begin
                    srem_reg <= s_try;
                    root_reg <= {root_reg[14:0], 1'b0};
                end
            end
            ST_CHK: begin
                mag_reg  <= root_reg;
                zero_reg <= (root_reg == 16'd0) || (root_reg <= {1'b0, zone})
                            || (zone == FULL_SCALE);
                span_reg <= FULL_SCALE - zone;
                negx_reg <= ax[15];
                negy_reg <= ay[15];
                uax_reg  <= ax[15] ? 16'(-ax) : 16'(ax);
                uay_reg  <= ay[15] ? 16'(-ay) : 16'(ay);
            end
            ST_MUL: begin
                diff_reg <= mclip - zone;
                den_reg  <= 31'(mag_reg) * 31'(span_reg);
            end
            ST_DVLD: begin
                // numerator is product << 15; the top bits seed the remainder
                rx_reg  <= {2'b00, prod_x[30:1]};
                ry_reg  <= {2'b00, prod_y[30:1]};
                lox_reg <= {prod_x[0], 15'd0};
                loy_reg <= {prod_y[0], 15'd0};
                qx_reg  <= '0;
                qy_reg  <= '0;
            end
            default: ;
        endcase
        if (state_reg == ST_DIV) begin
            rx_reg  <= (tx >= {1'b0, den_reg}) ? tx - {1'b0, den_reg} : tx;
            ry_reg  <= (ty >= {1'b0, den_reg}) ? ty - {1'b0, den_reg} : ty;
            lox_reg <= {lox_reg[14:0], 1'b0};
            loy_reg <= {loy_reg[14:0], 1'b0};
            qx_reg  <= qx_next;
            qy_reg  <= qy_next;
        end
        if (state_reg == ST_DIV && cnt_reg == 4'd15) begin
            if (stick_reg) begin
                dx_reg <= dx_next;
                dy_reg <= dy_next;
            end else begin
                left_dx_reg <= dx_next;
                left_dy_reg <= dy_next;
            end
        end
    end

endmodule
